// ===== sv/assert_macros.svh =====
// Assertion macros shared by the predictor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SVPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SVPQ_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/svpq_pkg.sv =====
// Types, constants and helper functions of the stride value predictor
`timescale 1ns / 1ps
`default_nettype none
package svpq_pkg;
  localparam int IDX_W      = 10;
  localparam int TBL_DEPTH  = 1 << IDX_W;
  localparam int Q_DEPTH    = 256;
  localparam int Q_W        = 8;
  localparam int TAG_W      = 48;
  localparam logic [8:0] INST_MAX = 9'd511;

  localparam logic [2:0] REQ_ENQ   = 3'd0;
  localparam logic [2:0] REQ_PRED  = 3'd1;
  localparam logic [2:0] REQ_TRAIN = 3'd2;
  localparam logic [2:0] REQ_RBACK = 3'd3;
  localparam logic [2:0] REQ_SQ    = 3'd4;

  localparam logic [2:0] CFG_CONF_MAX = 3'd0;
  localparam logic [2:0] CFG_CONF_INC = 3'd1;
  localparam logic [2:0] CFG_CONF_DEC = 3'd2;
  localparam logic [2:0] CFG_SRL      = 3'd3;
  localparam logic [2:0] CFG_ERL      = 3'd4;
  localparam logic [2:0] CFG_TAG_W    = 3'd5;

  localparam logic [1:0] HIT_MISS = 2'd0;
  localparam logic [1:0] HIT_UNC  = 2'd1;
  localparam logic [1:0] HIT_CONF = 2'd2;

  typedef struct packed {
    logic [4:0] conf_max;
    logic [4:0] conf_inc;
    logic [4:0] conf_dec;
    logic [4:0] stride_replace_limit;
    logic [4:0] entry_replace_limit;
    logic [5:0] tag_width;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [63:0]      last;
    logic [63:0]      stride;
    logic [4:0]       conf;
  } entry_t;

  function automatic logic [IDX_W-1:0] idx_of(input logic [63:0] pc);
    return pc[2 +: IDX_W];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [63:0] pc, input logic [5:0] tw);
    logic [5:0]       w;
    logic [TAG_W-1:0] m;
    w = (tw > 6'd48) ? 6'd48 : tw;
    m = ~({TAG_W{1'b1}} << w);
    return pc[2 + IDX_W +: TAG_W] & m;
  endfunction
endpackage
`default_nettype wire

// ===== sv/svpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module svpq_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/svpq_upd.sv =====
// Entry update unit: stride and confidence training on a tag hit
`timescale 1ns / 1ps
`default_nettype none
module svpq_upd import svpq_pkg::*; (
  input  wire entry_t      ent,
  input  wire logic [63:0] value,
  input  wire cfg_t        cfg,
  output entry_t           upd
);
  logic [63:0] ns;
  logic [5:0]  csum;

  always_comb begin
    ns   = value - ent.last;
    csum = {1'b0, ent.conf} + {1'b0, cfg.conf_inc};
    upd  = ent;
    upd.last = value;
    if (ent.stride == ns) begin
      upd.conf = (csum < {1'b0, cfg.conf_max}) ? csum[4:0] : cfg.conf_max;
    end else begin
      if (ent.conf <= cfg.stride_replace_limit) begin
        upd.stride = ns;
      end
      // drop to zero on a zero step or when the step would underflow
      if (cfg.conf_dec == 5'd0 || ent.conf <= cfg.conf_dec) begin
        upd.conf = 5'd0;
      end else begin
        upd.conf = ent.conf - cfg.conf_dec;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/stride_value_predictor_queue_core.sv =====
// Top level: stride value predictor with in-flight queue and its sequencer
// Enqueue, unknown requests and no-op rollbacks finish at dispatch; predict reads the table,
//   multiplies, then adds; train replace walks each occupied queue entry; rollback unwinds entry by entry.
// Squash (and rollback to head) clears all instance counts.
// One beat at a time: the input stalls until the result beat is taken.
// Reset: synchronous, active low; a clearing pass over the whole table
//   follows, with the input stalled; config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stride_value_predictor_queue_core import svpq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [63:0] in_pc,
  input  wire logic [63:0] in_actual_value,
  input  wire logic [7:0]  in_checkpoint_tail,
  input  wire logic        in_checkpoint_phase,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_error,
  output logic [1:0]       out_hit_status,
  output logic [63:0]      out_pred_value,
  output logic [7:0]       out_slot_index,
  output logic [7:0]       out_tail_index,
  output logic             out_tail_phase,
  output logic [8:0]       out_free_slots,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [5:0]  cfg_wdata
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_P_RD  = 4'd3;
  localparam logic [3:0] S_P_MUL = 4'd4;
  localparam logic [3:0] S_P_ADD = 4'd5;
  localparam logic [3:0] S_T_RD  = 4'd6;
  localparam logic [3:0] S_T_UPD = 4'd7;
  localparam logic [3:0] S_W_RD  = 4'd8;
  localparam logic [3:0] S_W_CMP = 4'd9;
  localparam logic [3:0] S_W_FIN = 4'd10;
  localparam logic [3:0] S_R_RD  = 4'd11;
  localparam logic [3:0] S_R_Q   = 4'd12;
  localparam logic [3:0] S_R_T   = 4'd13;
  localparam logic [3:0] S_SQ    = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TBL_DEPTH - 1);

  logic [3:0]            state_r, state_nxt;
  logic [2:0]            req_r, req_nxt;
  logic [63:0]           pc_r, pc_nxt, val_r, val_nxt;
  logic [Q_W-1:0]        ck_r, ck_nxt;
  logic                  ckph_r, ckph_nxt;
  logic [Q_W:0]          hpos_r, hpos_nxt, tpos_r, tpos_nxt;
  logic                  err_r, err_nxt;
  logic [1:0]            hit_r, hit_nxt;
  logic [63:0]           pred_r, pred_nxt, last_r, last_nxt, prod_r, prod_nxt;
  logic [Q_W-1:0]        slot_r, slot_nxt, pos_r, pos_nxt;
  logic [Q_W:0]          k_r, k_nxt, cnt_r, cnt_nxt, rb_r, rb_nxt;
  logic [63:0]           pq_r, pq_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  cfg_t                  cfg_r, cfg_nxt;

  logic                  tab_we;
  logic [IDX_W-1:0]      tab_waddr, tab_raddr;
  entry_t                tab_wdata, tab_rdata, upd_ent;
  logic                  inst_we;
  logic [IDX_W-1:0]      inst_waddr, inst_raddr;
  logic [8:0]            inst_wdata, inst_rdata, inst_inc;
  logic                  q_we;
  logic [Q_W-1:0]        q_waddr, q_raddr;
  logic [63:0]           q_wdata, q_rdata;

  logic [Q_W:0]          occ, back_n;
  logic                  tag_hit;

  svpq_ram #(.W($bits(entry_t)), .D(TBL_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );
  svpq_ram #(.W(9), .D(TBL_DEPTH)) u_inst (
    .clk(clk), .we(inst_we), .waddr(inst_waddr), .wdata(inst_wdata),
    .raddr(inst_raddr), .rdata(inst_rdata)
  );
  svpq_ram #(.W(64), .D(Q_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  svpq_upd u_upd (.ent(tab_rdata), .value(val_r), .cfg(cfg_r), .upd(upd_ent));

  // Occupancy and rollback distance fall out of phase-extended positions.
  assign occ      = tpos_r - hpos_r;
  assign back_n   = tpos_r - {ckph_r, ck_r};
  assign inst_inc = (inst_rdata < INST_MAX) ? inst_rdata + 9'd1 : inst_rdata;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r; pc_nxt = pc_r; val_nxt = val_r;
    ck_nxt = ck_r; ckph_nxt = ckph_r;
    hpos_nxt = hpos_r; tpos_nxt = tpos_r;
    err_nxt = err_r; hit_nxt = hit_r; pred_nxt = pred_r; slot_nxt = slot_r;
    last_nxt = last_r; prod_nxt = prod_r; pos_nxt = pos_r;
    k_nxt = k_r; cnt_nxt = cnt_r; rb_nxt = rb_r; pq_nxt = pq_r; clr_nxt = clr_r;
    cfg_nxt = cfg_r;

    tab_we = 1'b0; tab_waddr = idx_of(pc_r); tab_wdata = upd_ent;
    tab_raddr = idx_of(pc_r);
    inst_we = 1'b0; inst_waddr = idx_of(pc_r); inst_wdata = '0;
    inst_raddr = idx_of(pc_r);
    q_we = 1'b0; q_waddr = tpos_r[Q_W-1:0]; q_wdata = pc_r; q_raddr = pos_r;
    tag_hit = (tab_rdata.tag == tag_of(pc_r, cfg_r.tag_width));

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONF_MAX: cfg_nxt.conf_max             = cfg_wdata[4:0];
        CFG_CONF_INC: cfg_nxt.conf_inc             = cfg_wdata[4:0];
        CFG_CONF_DEC: cfg_nxt.conf_dec             = cfg_wdata[4:0];
        CFG_SRL:      cfg_nxt.stride_replace_limit = cfg_wdata[4:0];
        CFG_ERL:      cfg_nxt.entry_replace_limit  = cfg_wdata[4:0];
        CFG_TAG_W:    cfg_nxt.tag_width            = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        // sweep the whole table back to zero after reset
        tab_we = 1'b1; tab_waddr = clr_r; tab_wdata = '0;
        inst_we = 1'b1; inst_waddr = clr_r; inst_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type; pc_nxt = in_pc; val_nxt = in_actual_value;
          ck_nxt = in_checkpoint_tail; ckph_nxt = in_checkpoint_phase;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        err_nxt = 1'b0; hit_nxt = HIT_MISS; pred_nxt = '0; slot_nxt = '0;
        state_nxt = S_OUT;
        case (req_r)
          REQ_ENQ: begin
            if (occ >= (Q_W+1)'(Q_DEPTH)) begin
              err_nxt = 1'b1;
            end else begin
              q_we = 1'b1;
              slot_nxt = tpos_r[Q_W-1:0];
              tpos_nxt = tpos_r + 1'b1;
            end
          end
          REQ_PRED: state_nxt = S_P_RD;
          REQ_TRAIN: begin
            if (occ == '0) err_nxt = 1'b1;
            else state_nxt = S_T_RD;
          end
          REQ_RBACK: begin
            if (back_n == occ && back_n != '0) begin
              tpos_nxt = hpos_r; clr_nxt = '0; state_nxt = S_SQ;
            end else if (back_n != '0 && back_n < occ) begin
              rb_nxt = back_n; state_nxt = S_R_RD;
            end
          end
          REQ_SQ: begin
            tpos_nxt = hpos_r; clr_nxt = '0; state_nxt = S_SQ;
          end
          default: ;
        endcase
      end
      S_P_RD: state_nxt = S_P_MUL;
      S_P_MUL: begin
        // bump the in-flight count, register the product before the add
        if (tag_hit) begin
          inst_we = 1'b1; inst_wdata = inst_inc;
          hit_nxt = (tab_rdata.conf == cfg_r.conf_max) ? HIT_CONF : HIT_UNC;
        end
        prod_nxt = 64'(tab_rdata.stride * inst_inc);
        last_nxt = tab_rdata.last;
        state_nxt = S_P_ADD;
      end
      S_P_ADD: begin
        if (hit_r != HIT_MISS) pred_nxt = last_r + prod_r;
        state_nxt = S_OUT;
      end
      S_T_RD: state_nxt = S_T_UPD;
      S_T_UPD: begin
        if (tag_hit) begin
          tab_we = 1'b1;
          inst_we = 1'b1;
          inst_wdata = (inst_rdata != '0) ? inst_rdata - 9'd1 : inst_rdata;
          hpos_nxt = hpos_r + 1'b1;
          state_nxt = S_OUT;
        end else if (tab_rdata.conf <= cfg_r.entry_replace_limit) begin
          tab_we = 1'b1;
          tab_wdata.tag = tag_of(pc_r, cfg_r.tag_width);
          tab_wdata.last = val_r; tab_wdata.stride = val_r; tab_wdata.conf = '0;
          pos_nxt = hpos_r[Q_W-1:0]; k_nxt = '0; cnt_nxt = '0;
          state_nxt = S_W_RD;
        end else begin
          hpos_nxt = hpos_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_W_RD: state_nxt = S_W_CMP;
      S_W_CMP: begin
        // count in-flight copies of this pc, head to tail
        if (q_rdata == pc_r) cnt_nxt = cnt_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = ((k_r + 1'b1) == occ) ? S_W_FIN : S_W_RD;
      end
      S_W_FIN: begin
        inst_we = 1'b1;
        inst_wdata = (cnt_r != '0) ? cnt_r - 1'b1 : '0;
        hpos_nxt = hpos_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_R_RD: begin
        q_raddr = tpos_r[Q_W-1:0] - 1'b1;
        tpos_nxt = tpos_r - 1'b1;
        state_nxt = S_R_Q;
      end
      S_R_Q: begin
        tab_raddr = idx_of(q_rdata);
        inst_raddr = idx_of(q_rdata);
        pq_nxt = q_rdata;
        state_nxt = S_R_T;
      end
      S_R_T: begin
        // drop one in-flight instance of the unwound pc
        inst_waddr = idx_of(pq_r);
        inst_wdata = inst_rdata - 9'd1;
        inst_we = (tab_rdata.tag == tag_of(pq_r, cfg_r.tag_width)) && (inst_rdata != '0);
        rb_nxt = rb_r - 1'b1;
        state_nxt = (rb_r == (Q_W+1)'(1)) ? S_OUT : S_R_RD;
      end
      S_SQ: begin
        inst_we = 1'b1; inst_waddr = clr_r; inst_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_LAST) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      hpos_r  <= '0;
      tpos_r  <= '0;
      cfg_r   <= '{conf_max: 5'd7, conf_inc: 5'd1, conf_dec: 5'd31,
                   stride_replace_limit: 5'd0, entry_replace_limit: 5'd0,
                   tag_width: 6'd14};
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hpos_r  <= hpos_nxt;
      tpos_r  <= tpos_nxt;
      cfg_r   <= cfg_nxt;
    end
    req_r <= req_nxt; pc_r <= pc_nxt; val_r <= val_nxt;
    ck_r <= ck_nxt; ckph_r <= ckph_nxt;
    err_r <= err_nxt; hit_r <= hit_nxt; pred_r <= pred_nxt; slot_r <= slot_nxt;
    last_r <= last_nxt; prod_r <= prod_nxt; pos_r <= pos_nxt;
    k_r <= k_nxt; cnt_r <= cnt_nxt; rb_r <= rb_nxt; pq_r <= pq_nxt;
  end

  // Hold the result beat in registers until the consumer takes it.
  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_error           = err_r;
  assign out_hit_status      = hit_r;
  assign out_pred_value      = pred_r;
  assign out_slot_index      = slot_r;
  assign out_tail_index      = tpos_r[Q_W-1:0];
  assign out_tail_phase      = tpos_r[Q_W];
  assign out_free_slots      = (Q_W+1)'(Q_DEPTH) - occ;

  `SVPQ_ASSERT_NR(a_rst_clear, (!rst_n) |=> (state_r == S_CLR), "reset must start clearing pass")
  `SVPQ_ASSERT(a_accept_busy, (in_valid && !in_stall) |=> (state_r != S_IDLE), "accept did not start work")
  `SVPQ_ASSERT(a_occ_range, occ <= (Q_W+1)'(Q_DEPTH), "queue occupancy beyond depth")
  `SVPQ_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "input taken while result pending")
endmodule
`default_nettype wire
